// ----- src/kpt_pkg.sv -----
// Package for the keyed presence table: sizes, codes, entry and result types.
// No dependencies; compiled first.
`default_nettype none

package kpt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int ID_BYTES    = 15;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

  localparam int ID_LO_W    = 64;
  localparam int ID_HI_W    = 56;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // id bytes beyond ID_BYTES are ignored and stored as zero
  localparam logic [ID_LO_W-1:0] ID_LO_MASK = (ID_BYTES >= 8) ? {ID_LO_W{1'b1}} :
      ((64'd1 << (8 * ID_BYTES)) - 64'd1);
  localparam logic [ID_HI_W-1:0] ID_HI_MASK = (ID_BYTES <= 8) ? {ID_HI_W{1'b0}} :
      ((56'd1 << (8 * ((ID_BYTES > 8) ? (ID_BYTES - 8) : 0))) - 56'd1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_ENTRY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // report status codes
  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_BAD_LEN = 3'd2;
  localparam logic [2:0] ST_BAD_MAG = 3'd3;
  localparam logic [2:0] ST_WEAK    = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  // one table entry as held in the RAM
  typedef struct packed {
    logic [ID_HI_W-1:0] id_high;
    logic [ID_LO_W-1:0] id_low;
    logic               flag;
    logic signed [7:0]  strength;
    logic [7:0]         charge;
    logic [TIME_W-1:0]  seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result transaction
  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         status;
    logic [3:0]         slot_index;
    logic [ID_LO_W-1:0] entry_id_low;
    logic [ID_HI_W-1:0] entry_id_high;
    logic               entry_occupied;
    logic signed [7:0]  entry_signal;
    logic [7:0]         entry_battery;
    logic [4:0]         busy_count;
    logic [4:0]         live_count;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ----- src/kpt_if.sv -----
// Valid/ready channel interfaces for report input and result output.
// Depends on kpt_pkg.
`default_nettype none

interface kpt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [kpt_pkg::TIME_W-1:0]   now_ms;
  logic [7:0]                   packet_length;
  logic [31:0]                  report_magic;
  logic [kpt_pkg::ID_LO_W-1:0]  node_id_low;
  logic [kpt_pkg::ID_HI_W-1:0]  node_id_high;
  logic signed [7:0]            signal_dbm;
  logic                         is_occupied;
  logic [7:0]                   battery_level;

  modport source (output valid, command, now_ms, packet_length, report_magic,
                  node_id_low, node_id_high, signal_dbm, is_occupied,
                  battery_level, input ready);
  modport sink   (input valid, command, now_ms, packet_length, report_magic,
                  node_id_low, node_id_high, signal_dbm, is_occupied,
                  battery_level, output ready);
endinterface

interface kpt_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [2:0]                   status;
  logic [3:0]                   slot_index;
  logic [kpt_pkg::ID_LO_W-1:0]  entry_id_low;
  logic [kpt_pkg::ID_HI_W-1:0]  entry_id_high;
  logic                         entry_occupied;
  logic signed [7:0]            entry_signal;
  logic [7:0]                   entry_battery;
  logic [4:0]                   busy_count;
  logic [4:0]                   live_count;
  logic                         last;

  modport source (output valid, kind, status, slot_index, entry_id_low,
                  entry_id_high, entry_occupied, entry_signal, entry_battery,
                  busy_count, live_count, last, input ready);
  modport sink   (input valid, kind, status, slot_index, entry_id_low,
                  entry_id_high, entry_occupied, entry_signal, entry_battery,
                  busy_count, live_count, last, output ready);
endinterface

`default_nettype wire

// ----- src/kpt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/keyed_presence_table_with_aging.sv -----
// Keyed presence table with aging eviction: top level.
// Depends on kpt_pkg, kpt_if (kpt_in_if, kpt_out_if) and kpt_ram.
`default_nettype none

// Usage
//   in_ch  : one transaction per command; command 0 is a node report, command 1
//            evicts stale entries and lists the table.
//   out_ch : a report gives one status transaction (last = 1); a list gives one
//            entry transaction per live slot in slot order, then a summary
//            (last = 1) with occupied and total counts.
//   cfg_*  : plain write port, to be written only while the block is idle; the block does not enforce it.
// Sequencing (one item at a time; in_ch.ready is high only while the sequencer idles)
//   Rejected report: status loaded from S_RESP once the output register is free.
//   Accepted report: S_SCAN reads every slot (one RAM read a cycle, compare in the
//   cycle after), then S_WR writes the entry and S_RESP gives the status.
//   List: per slot a RAM read (S_LRD), then check/emit (S_LCHK, held by any output
//   stall), then the summary. The single read port makes read and check separate steps.
// Reset
//   Synchronous, active low. Valid marks, sequencer and output valid clear at
//   once; configuration registers go to their defaults. The entry RAM is not cleared.
// Back-pressure
//   A result waits in the output register; the sequencer holds at the next
//   result until out_ch.ready frees it; the next item may be accepted meanwhile.

module keyed_presence_table_with_aging (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  kpt_in_if.sink                                 in_ch,
  kpt_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [kpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = kpt_pkg::SLOT_W;
  localparam int CW = kpt_pkg::CNT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // report: read all slots, find match / free
  localparam logic [2:0] S_WR   = 3'd2;  // report: write entry back
  localparam logic [2:0] S_RESP = 3'd3;  // report: emit status
  localparam logic [2:0] S_LRD  = 3'd4;  // list: read slot
  localparam logic [2:0] S_LCHK = 3'd5;  // list: evict or emit slot
  localparam logic [2:0] S_SUM  = 3'd6;  // list: emit summary

  // configuration
  logic signed [7:0]              thr_r;
  logic [kpt_pkg::TIME_W-1:0]     timeout_r;
  logic [31:0]                    magic_r;
  logic [7:0]                     length_r;

  // captured item
  logic [kpt_pkg::TIME_W-1:0]     now_r;
  logic [kpt_pkg::ID_LO_W-1:0]    id_lo_r;
  logic [kpt_pkg::ID_HI_W-1:0]    id_hi_r;
  logic                           flag_r;
  logic signed [7:0]              sig_r;
  logic [7:0]                     bat_r;

  // sequencer
  logic [2:0]                     state_r;
  logic [CW-1:0]                  cnt_r;
  logic [SW-1:0]                  prev_addr_r;
  logic [kpt_pkg::TABLE_SLOTS-1:0] valid_r;
  logic                           hit_r;
  logic [SW-1:0]                  hit_slot_r;
  logic                           free_r;
  logic [SW-1:0]                  free_slot_r;
  logic [2:0]                     status_r;
  logic [SW-1:0]                  resp_slot_r;
  logic [CW-1:0]                  occ_cnt_r;
  logic [CW-1:0]                  tot_cnt_r;

  // output register
  kpt_pkg::result_t               out_r;
  logic                           out_valid_r;
  kpt_pkg::result_t               out_nxt;
  logic                           out_load;

  // RAM
  logic                           ram_we;
  logic [SW-1:0]                  ram_waddr;
  kpt_pkg::entry_t                wr_entry;
  logic [SW-1:0]                  rd_addr;
  logic [kpt_pkg::ENTRY_W-1:0]    rd_data;
  kpt_pkg::entry_t                rd_entry;

  logic                           can_load;
  logic                           aged;
  logic                           id_eq;
  logic                           list_done;

  kpt_ram #(
    .WIDTH (kpt_pkg::ENTRY_W),
    .DEPTH (kpt_pkg::TABLE_SLOTS),
    .ADDR_W(SW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign rd_entry  = kpt_pkg::entry_t'(rd_data);
  assign rd_addr   = cnt_r[SW-1:0];
  assign can_load  = !out_valid_r || out_ch.ready;
  // wrapping age, strictly beyond the timeout
  assign aged      = (now_r - rd_entry.seen) > timeout_r;
  assign id_eq     = (rd_entry.id_low == id_lo_r) && (rd_entry.id_high == id_hi_r);
  assign list_done = rd_addr == SW'(kpt_pkg::TABLE_SLOTS - 1);

  always_comb begin
    ram_we           = (state_r == S_WR) && (hit_r || free_r);
    ram_waddr        = hit_r ? hit_slot_r : free_slot_r;
    wr_entry.id_low  = id_lo_r;
    wr_entry.id_high = id_hi_r;
    wr_entry.flag    = flag_r;
    wr_entry.strength = sig_r;
    wr_entry.charge  = bat_r;
    wr_entry.seen    = now_r;
  end

  // next result and when it is loaded into the output register
  always_comb begin
    out_load = 1'b0;
    out_nxt  = '0;
    unique case (state_r)
      S_RESP: begin
        if (can_load) begin
          out_load           = 1'b1;
          out_nxt.kind       = kpt_pkg::KIND_STATUS;
          out_nxt.status     = status_r;
          out_nxt.slot_index = 4'(resp_slot_r);
          out_nxt.last       = 1'b1;
        end
      end
      S_LCHK: begin
        if (can_load && valid_r[rd_addr] && !aged) begin
          out_load               = 1'b1;
          out_nxt.kind           = kpt_pkg::KIND_ENTRY;
          out_nxt.slot_index     = 4'(rd_addr);
          out_nxt.entry_id_low   = rd_entry.id_low;
          out_nxt.entry_id_high  = rd_entry.id_high;
          out_nxt.entry_occupied = rd_entry.flag;
          out_nxt.entry_signal   = rd_entry.strength;
          out_nxt.entry_battery  = rd_entry.charge;
        end
      end
      S_SUM: begin
        if (can_load) begin
          out_load           = 1'b1;
          out_nxt.kind       = kpt_pkg::KIND_SUMMARY;
          out_nxt.busy_count = 5'(occ_cnt_r);
          out_nxt.live_count = 5'(tot_cnt_r);
          out_nxt.last       = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.status         = out_r.status;
  assign out_ch.slot_index     = out_r.slot_index;
  assign out_ch.entry_id_low   = out_r.entry_id_low;
  assign out_ch.entry_id_high  = out_r.entry_id_high;
  assign out_ch.entry_occupied = out_r.entry_occupied;
  assign out_ch.entry_signal   = out_r.entry_signal;
  assign out_ch.entry_battery  = out_r.entry_battery;
  assign out_ch.busy_count     = out_r.busy_count;
  assign out_ch.live_count     = out_r.live_count;
  assign out_ch.last           = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= -8'sd80;
      timeout_r   <= 32'd30000;
      magic_r     <= '0;
      length_r    <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          kpt_pkg::CFG_RSSI_THRESHOLD:  thr_r     <= cfg_data[7:0];
          kpt_pkg::CFG_ENTRY_TIMEOUT:   timeout_r <= cfg_data;
          kpt_pkg::CFG_EXPECTED_MAGIC:  magic_r   <= cfg_data;
          kpt_pkg::CFG_EXPECTED_LENGTH: length_r  <= cfg_data[7:0];
        endcase
      end

      // output register: a load wins over the drain
      if (out_load) begin
        out_r       <= out_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      prev_addr_r <= rd_addr;

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            now_r       <= in_ch.now_ms;
            id_lo_r     <= in_ch.node_id_low & kpt_pkg::ID_LO_MASK;
            id_hi_r     <= in_ch.node_id_high & kpt_pkg::ID_HI_MASK;
            flag_r      <= in_ch.is_occupied;
            sig_r       <= in_ch.signal_dbm;
            bat_r       <= in_ch.battery_level;
            cnt_r       <= '0;
            hit_r       <= 1'b0;
            free_r      <= 1'b0;
            occ_cnt_r   <= '0;
            tot_cnt_r   <= '0;
            resp_slot_r <= '0;
            if (in_ch.command) begin
              state_r <= S_LRD;
            end else if (in_ch.packet_length != length_r) begin
              status_r <= kpt_pkg::ST_BAD_LEN;
              state_r  <= S_RESP;
            end else if (in_ch.report_magic != magic_r) begin
              status_r <= kpt_pkg::ST_BAD_MAG;
              state_r  <= S_RESP;
            end else if (in_ch.signal_dbm < thr_r) begin
              status_r <= kpt_pkg::ST_WEAK;
              state_r  <= S_RESP;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // data of the slot read last cycle is compared now
          if (cnt_r != '0) begin
            if (valid_r[prev_addr_r]) begin
              if (!hit_r && id_eq) begin
                hit_r      <= 1'b1;
                hit_slot_r <= prev_addr_r;
              end
            end else if (!free_r) begin
              free_r      <= 1'b1;
              free_slot_r <= prev_addr_r;
            end
          end
          if (cnt_r == CW'(kpt_pkg::TABLE_SLOTS)) begin
            state_r <= S_WR;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end

        S_WR: begin
          // a match wins over the lowest free slot
          if (hit_r) begin
            status_r           <= kpt_pkg::ST_UPDATED;
            resp_slot_r        <= hit_slot_r;
            valid_r[hit_slot_r] <= 1'b1;
          end else if (free_r) begin
            status_r            <= kpt_pkg::ST_NEW;
            resp_slot_r         <= free_slot_r;
            valid_r[free_slot_r] <= 1'b1;
          end else begin
            status_r <= kpt_pkg::ST_FULL;
          end
          state_r <= S_RESP;
        end

        S_RESP: begin
          if (can_load) begin
            state_r <= S_IDLE;
          end
        end

        S_LRD: begin
          state_r <= S_LCHK;
        end

        S_LCHK: begin
          // eviction and listing share one pass: each slot only affects itself
          if (!valid_r[rd_addr] || aged || can_load) begin
            if (valid_r[rd_addr]) begin
              if (aged) begin
                valid_r[rd_addr] <= 1'b0;
              end else begin
                tot_cnt_r <= tot_cnt_r + CW'(1);
                occ_cnt_r <= occ_cnt_r + CW'(rd_entry.flag);
              end
            end
            if (list_done) begin
              state_r <= S_SUM;
            end else begin
              cnt_r   <= cnt_r + CW'(1);
              state_r <= S_LRD;
            end
          end
        end

        S_SUM: begin
          if (can_load) begin
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_keyed_presence_table_with_aging.sv -----
// Self-checking bench for the keyed presence table with aging: directed rows first,
// then randomised phases scored against a behavioural model of the table.
// Needs kpt_pkg, kpt_if (kpt_in_if, kpt_out_if) and the RTL top level.
`timescale 1ns / 1ps

module tb_keyed_presence_table_with_aging;

  // input command codes
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  localparam int POOL_SIZE   = 20;   // more ids than slots, so the table fills
  localparam int HOLD_AT     = 100;  // transaction count that starts the long sink stall
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000; // cycles without any handshake before giving up
  localparam int DRAIN_WAIT  = 50;

  // one input transaction
  typedef struct {
    logic                         command;
    logic [kpt_pkg::TIME_W-1:0]   now_ms;
    logic [7:0]                   packet_length;
    logic [31:0]                  report_magic;
    logic [kpt_pkg::ID_LO_W-1:0]  node_id_low;
    logic [kpt_pkg::ID_HI_W-1:0]  node_id_high;
    logic signed [7:0]            signal_dbm;
    logic                         is_occupied;
    logic [7:0]                   battery_level;
  } report_t;

  // directed row: typed rows carry their single result, the rest go to the model
  typedef struct {
    report_t          item;
    bit               typed;
    kpt_pkg::result_t want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                           cfg_we;
  logic [kpt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kpt_pkg::CFG_DATA_W-1:0] cfg_data;

  kpt_in_if  in_ch ();
  kpt_out_if out_ch ();

  keyed_presence_table_with_aging u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the table: register copies and per-slot state. Only live slots' data
  // is ever used, so the data arrays need no reset.
  // ---------------------------------------------------------------------------
  logic signed [7:0] thr_dbm;
  logic [31:0]       timeout_ms;
  logic [31:0]       magic_word;
  logic [7:0]        length_bytes;

  bit                          slot_live [kpt_pkg::TABLE_SLOTS];
  logic [kpt_pkg::ID_LO_W-1:0] slot_id_lo [kpt_pkg::TABLE_SLOTS];
  logic [kpt_pkg::ID_HI_W-1:0] slot_id_hi [kpt_pkg::TABLE_SLOTS];
  logic                        slot_occ [kpt_pkg::TABLE_SLOTS];
  logic signed [7:0]           slot_sig [kpt_pkg::TABLE_SLOTS];
  logic [7:0]                  slot_batt [kpt_pkg::TABLE_SLOTS];
  logic [kpt_pkg::TIME_W-1:0]  slot_seen [kpt_pkg::TABLE_SLOTS];

  kpt_pkg::result_t pending_results [$];   // results still owed by the block, oldest first

  // random stimulus state
  logic [kpt_pkg::ID_LO_W-1:0] pool_lo [POOL_SIZE];
  logic [kpt_pkg::ID_HI_W-1:0] pool_hi [POOL_SIZE];
  logic [kpt_pkg::TIME_W-1:0]  clock_ms;
  int                          items_sent;
  int                          mismatches;
  bit                          calm;        // last part of the run: no idling on either side

  function automatic kpt_pkg::result_t status_res(input logic [2:0] st, input int slot);
    kpt_pkg::result_t r;
    r = '0;
    r.kind       = kpt_pkg::KIND_STATUS;
    r.status     = st;
    r.slot_index = 4'(slot);
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic kpt_pkg::result_t summary_res(input int occ, input int tot);
    kpt_pkg::result_t r;
    r = '0;
    r.kind       = kpt_pkg::KIND_SUMMARY;
    r.busy_count = 5'(occ);
    r.live_count = 5'(tot);
    r.last       = 1'b1;
    return r;
  endfunction

  // Works out every result one accepted transaction causes and updates the table.
  function automatic void presence_step(input report_t it,
                                        output kpt_pkg::result_t res[$]);
    int                          slot;
    int                          total;
    int                          occ;
    bit                          hit;
    logic [kpt_pkg::ID_LO_W-1:0] idl;
    logic [kpt_pkg::ID_HI_W-1:0] idh;
    logic [kpt_pkg::TIME_W-1:0]  age;
    kpt_pkg::result_t            r;
    res.delete();
    if (it.command == CMD_REPORT) begin
      idl  = it.node_id_low & kpt_pkg::ID_LO_MASK;
      idh  = it.node_id_high & kpt_pkg::ID_HI_MASK;
      slot = -1;
      hit  = 1'b0;
      // length, then magic, then signal, then room in the table
      if (it.packet_length != length_bytes) begin
        res.push_back(status_res(kpt_pkg::ST_BAD_LEN, 0));
      end else if (it.report_magic != magic_word) begin
        res.push_back(status_res(kpt_pkg::ST_BAD_MAG, 0));
      end else if (it.signal_dbm < thr_dbm) begin
        res.push_back(status_res(kpt_pkg::ST_WEAK, 0));
      end else begin
        // a matching live id wins over any free slot seen earlier
        for (int i = 0; i < kpt_pkg::TABLE_SLOTS; i++) begin
          if (!hit) begin
            if (slot_live[i] && slot_id_lo[i] == idl && slot_id_hi[i] == idh) begin
              slot = i;
              hit  = 1'b1;
            end else if (!slot_live[i] && slot < 0) begin
              slot = i;
            end
          end
        end
        if (slot < 0) begin
          res.push_back(status_res(kpt_pkg::ST_FULL, 0));
        end else begin
          slot_id_lo[slot] = idl;
          slot_id_hi[slot] = idh;
          slot_occ[slot]   = it.is_occupied;
          slot_sig[slot]   = it.signal_dbm;
          slot_batt[slot]  = it.battery_level;
          slot_seen[slot]  = it.now_ms;
          slot_live[slot]  = 1'b1;
          res.push_back(status_res(hit ? kpt_pkg::ST_UPDATED : kpt_pkg::ST_NEW, slot));
        end
      end
    end else begin
      total = 0;
      occ   = 0;
      // evict on wrapping age strictly above the timeout, then list in slot order
      for (int i = 0; i < kpt_pkg::TABLE_SLOTS; i++) begin
        age = it.now_ms - slot_seen[i];
        if (slot_live[i] && age > timeout_ms) slot_live[i] = 1'b0;
      end
      for (int i = 0; i < kpt_pkg::TABLE_SLOTS; i++) begin
        if (slot_live[i]) begin
          total++;
          if (slot_occ[i]) occ++;
          r = '0;
          r.kind           = kpt_pkg::KIND_ENTRY;
          r.slot_index     = 4'(i);
          r.entry_id_low   = slot_id_lo[i];
          r.entry_id_high  = slot_id_hi[i];
          r.entry_occupied = slot_occ[i];
          r.entry_signal   = slot_sig[i];
          r.entry_battery  = slot_batt[i];
          res.push_back(r);
        end
      end
      res.push_back(summary_res(occ, total));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t rpt(input logic [31:0] now, input logic [7:0] len,
                                    input logic [31:0] magic, input logic [63:0] idl,
                                    input logic [55:0] idh, input logic signed [7:0] sig,
                                    input logic occ, input logic [7:0] bat,
                                    input bit typed, input kpt_pkg::result_t want);
    stim_row_t row;
    row.item.command       = CMD_REPORT;
    row.item.now_ms        = now;
    row.item.packet_length = len;
    row.item.report_magic  = magic;
    row.item.node_id_low   = idl;
    row.item.node_id_high  = idh;
    row.item.signal_dbm    = sig;
    row.item.is_occupied   = occ;
    row.item.battery_level = bat;
    row.typed              = typed;
    row.want               = want;
    return row;
  endfunction

  function automatic stim_row_t lst(input logic [31:0] now, input bit typed,
                                    input kpt_pkg::result_t want);
    stim_row_t row;
    row = rpt(now, 8'd0, 32'd0, 64'd0, 56'd0, 8'sd0, 1'b0, 8'd0, typed, want);
    row.item.command = CMD_LIST;
    return row;
  endfunction

  // Random transaction for the current register values. Roughly 70% of reports
  // are well formed so the table really fills, ages and lists; the rest are
  // broken on length, magic or signal. Lists carry random noise in the report
  // fields, which the block must ignore.
  function automatic report_t next_item(input int step_max, input int fresh_pct);
    report_t it;
    int      form;
    int      pick;
    int      span;
    clock_ms = clock_ms + 32'($urandom_range(0, step_max));
    it.command       = ($urandom_range(0, 4) == 0) ? CMD_LIST : CMD_REPORT;
    it.now_ms        = clock_ms;
    it.packet_length = 8'($urandom_range(0, 250));
    it.report_magic  = $urandom;
    if ($urandom_range(0, 99) < fresh_pct) begin
      it.node_id_low  = {$urandom, $urandom};
      it.node_id_high = 56'({$urandom, $urandom});
    end else begin
      pick = $urandom_range(0, POOL_SIZE - 1);
      it.node_id_low  = pool_lo[pick];
      it.node_id_high = pool_hi[pick];
    end
    it.signal_dbm    = 8'(-int'($urandom_range(0, 128)));
    it.is_occupied   = 1'($urandom);
    it.battery_level = 8'($urandom);
    form = $urandom_range(0, 9);
    span = -int'(thr_dbm);
    if (it.command == CMD_REPORT && form > 0) begin
      it.packet_length = length_bytes;
      if (form > 1) it.report_magic = magic_word;
      else if (it.report_magic == magic_word) it.report_magic = ~magic_word;
      if (form == 2 && span < 128) begin
        it.signal_dbm = 8'(-int'($urandom_range(span + 1, 128)));
      end else if (form > 2) begin
        it.signal_dbm = 8'(-int'($urandom_range(0, span)));
      end
    end else if (it.command == CMD_REPORT && it.packet_length == length_bytes) begin
      it.packet_length = (length_bytes == 8'd250) ? 8'd0 : length_bytes + 8'd1;
    end
    return it;
  endfunction

  // Offer one transaction, hold it until taken, then log what it must cause.
  // Called and returning on a rising edge; valid is left high for the caller.
  task automatic issue(input stim_row_t row);
    kpt_pkg::result_t outs[$];
    in_ch.valid         <= 1'b1;
    in_ch.command       <= row.item.command;
    in_ch.now_ms        <= row.item.now_ms;
    in_ch.packet_length <= row.item.packet_length;
    in_ch.report_magic  <= row.item.report_magic;
    in_ch.node_id_low   <= row.item.node_id_low;
    in_ch.node_id_high  <= row.item.node_id_high;
    in_ch.signal_dbm    <= row.item.signal_dbm;
    in_ch.is_occupied   <= row.item.is_occupied;
    in_ch.battery_level <= row.item.battery_level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    presence_step(row.item, outs);
    if (row.typed) pending_results.push_back(row.want);
    else foreach (outs[k]) pending_results.push_back(outs[k]);
    items_sent++;
  endtask

  // random source gap after a transaction
  task automatic pace();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic write_cfg(input logic [kpt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Registers only change with the block idle: nothing offered, nothing owed.
  task automatic configure(input logic signed [7:0] thr, input logic [31:0] tmo,
                           input logic [31:0] mag, input logic [7:0] len);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_cfg(kpt_pkg::CFG_RSSI_THRESHOLD, {{24{thr[7]}}, thr});
    write_cfg(kpt_pkg::CFG_ENTRY_TIMEOUT, tmo);
    write_cfg(kpt_pkg::CFG_EXPECTED_MAGIC, mag);
    write_cfg(kpt_pkg::CFG_EXPECTED_LENGTH, {24'd0, len});
    cfg_we       <= 1'b0;
    thr_dbm      = thr;
    timeout_ms   = tmo;
    magic_word   = mag;
    length_bytes = len;
  endtask

  // One random phase. At pause_at the source stops until every owed result is in.
  task automatic run_phase(input int count, input int step_max, input int fresh_pct,
                           input int pause_at);
    stim_row_t row;
    row.typed = 1'b0;
    row.want  = '0;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) begin
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      row.item = next_item(step_max, fresh_pct);
      issue(row);
      pace();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t directed_rows [$];
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_REPORT;
    in_ch.now_ms        <= '0;
    in_ch.packet_length <= '0;
    in_ch.report_magic  <= '0;
    in_ch.node_id_low   <= '0;
    in_ch.node_id_high  <= '0;
    in_ch.signal_dbm    <= '0;
    in_ch.is_occupied   <= 1'b0;
    in_ch.battery_level <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= kpt_pkg::CFG_RSSI_THRESHOLD;
    cfg_data            <= '0;

    // model state as the block leaves reset
    thr_dbm      = -8'sd80;
    timeout_ms   = 32'd30000;
    magic_word   = 32'd0;
    length_bytes = 8'd0;
    clock_ms     = 32'd0;
    items_sent   = 0;
    mismatches   = 0;
    calm         = 1'b0;

    // every fourth pooled id is short, zero-padded above byte 7
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_lo[i] = {$urandom, $urandom};
      pool_hi[i] = (i % 4 == 0) ? '0 : 56'({$urandom, $urandom});
    end

    // Directed rows, run with the reset register values (threshold -80 dBm,
    // timeout 30000 ms, magic 0, length 0).
    // empty table straight after reset
    directed_rows.push_back(lst(32'd0, 1'b1, summary_res(0, 0)));
    // each rejection on its own, then precedence of the checks
    directed_rows.push_back(rpt(32'd10, 8'd1, 32'd0, 64'h1, 56'h0, -8'sd10, 1'b1, 8'd50,
                                1'b1, status_res(kpt_pkg::ST_BAD_LEN, 0)));
    directed_rows.push_back(rpt(32'd10, 8'd0, 32'd1, 64'h1, 56'h0, -8'sd10, 1'b1, 8'd50,
                                1'b1, status_res(kpt_pkg::ST_BAD_MAG, 0)));
    directed_rows.push_back(rpt(32'd10, 8'd0, 32'd0, 64'h1, 56'h0, -8'sd81, 1'b1, 8'd50,
                                1'b1, status_res(kpt_pkg::ST_WEAK, 0)));
    directed_rows.push_back(rpt(32'd10, 8'd250, 32'hFFFF_FFFF, 64'h1, 56'h0, -8'sd128,
                                1'b0, 8'd0, 1'b1, status_res(kpt_pkg::ST_BAD_LEN, 0)));
    directed_rows.push_back(rpt(32'd10, 8'd0, 32'h8000_0000, 64'h1, 56'h0, -8'sd128,
                                1'b0, 8'd0, 1'b1, status_res(kpt_pkg::ST_BAD_MAG, 0)));
    // signal exactly on the threshold is kept; all-ones id goes in slot 0
    directed_rows.push_back(rpt(32'd100, 8'd0, 32'd0, '1, '1, -8'sd80, 1'b1, 8'd255,
                                1'b1, status_res(kpt_pkg::ST_NEW, 0)));
    directed_rows.push_back(rpt(32'd150, 8'd0, 32'd0, '1, '1, 8'sd0, 1'b0, 8'd0,
                                1'b1, status_res(kpt_pkg::ST_UPDATED, 0)));
    // ids differing in a single bit are distinct entries
    directed_rows.push_back(rpt(32'd200, 8'd0, 32'd0, 64'h0, 56'h0, -8'sd1, 1'b1, 8'h5A,
                                1'b0, '0));
    directed_rows.push_back(rpt(32'd210, 8'd0, 32'd0, 64'h1, 56'h0, -8'sd40, 1'b0, 8'hA5,
                                1'b0, '0));
    directed_rows.push_back(rpt(32'd220, 8'd0, 32'd0, 64'h0, 56'h80_0000_0000_0000,
                                -8'sd79, 1'b1, 8'd1, 1'b0, '0));
    // age equal to the timeout survives, one more millisecond evicts
    directed_rows.push_back(lst(32'd30150, 1'b0, '0));
    directed_rows.push_back(lst(32'd30151, 1'b0, '0));
    // evicted slot 0 is the lowest free one again
    directed_rows.push_back(rpt(32'd30160, 8'd0, 32'd0, 64'h0000_0000_6564_6F6E, 56'h0,
                                -8'sd60, 1'b1, 8'd77, 1'b0, '0));
    // age across the 32-bit wrap of the clock
    directed_rows.push_back(rpt(32'hFFFF_FFF0, 8'd0, 32'd0, 64'h0123_4567_89AB_CDEF,
                                56'hFE_DCBA_9876_5432, -8'sd20, 1'b0, 8'd128, 1'b0, '0));
    directed_rows.push_back(lst(32'h0000_0010, 1'b0, '0));
    directed_rows.push_back(lst(32'h0000_002F, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      issue(directed_rows[r]);
      pace();
    end

    // widest acceptance, instant eviction
    configure(-8'sd128, 32'd0, 32'hFFFF_FFFF, 8'd250);
    run_phase(30, 3, 12, -1);
    // strongest threshold, nothing ever ages out: the table runs full
    configure(8'sd0, 32'hFFFF_FFFF, 32'd0, 8'd0);
    run_phase(45, 50, 50, -1);
    // random settings; the long sink stall falls early in this phase
    configure(8'(-int'($urandom_range(0, 128))), 32'($urandom_range(0, 3000)),
              $urandom, 8'($urandom_range(0, 250)));
    run_phase(30, 400, 12, -1);
    // random clock origin, so wrapping ages turn up; source drains once mid-phase
    clock_ms = $urandom;
    configure(8'(-int'($urandom_range(0, 128))), 32'($urandom_range(0, 3000)),
              $urandom, 8'($urandom_range(0, 250)));
    run_phase(30, 400, 12, 12);
    // back-to-back traffic to finish
    configure(8'(-int'($urandom_range(0, 128))), 32'($urandom_range(0, 3000)),
              $urandom, 8'($urandom_range(0, 250)));
    calm = 1'b1;
    run_phase(30, 400, 12, -1);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);   // catch any stray trailing result
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, one long hold-off so the block backs up and
  // refuses input, and no stalls once the run goes calm.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: each result transaction against the oldest owed one
  // ---------------------------------------------------------------------------
  kpt_pkg::result_t want_r;

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, got kind %0d status %0d slot %0d",
                 $time, out_ch.kind, out_ch.status, out_ch.slot_index);
        mismatches++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("kind", 64'(want_r.kind), 64'(out_ch.kind));
        check_field("status", 64'(want_r.status), 64'(out_ch.status));
        check_field("slot_index", 64'(want_r.slot_index), 64'(out_ch.slot_index));
        check_field("entry_id_low", want_r.entry_id_low, out_ch.entry_id_low);
        check_field("entry_id_high", 64'(want_r.entry_id_high),
                    64'(out_ch.entry_id_high));
        check_field("entry_occupied", 64'(want_r.entry_occupied),
                    64'(out_ch.entry_occupied));
        check_field("entry_signal", 64'(want_r.entry_signal), 64'(out_ch.entry_signal));
        check_field("entry_battery", 64'(want_r.entry_battery),
                    64'(out_ch.entry_battery));
        check_field("busy_count", 64'(want_r.busy_count), 64'(out_ch.busy_count));
        check_field("live_count", 64'(want_r.live_count), 64'(out_ch.live_count));
        check_field("last", 64'(want_r.last), 64'(out_ch.last));
      end
    end
  end

  // Watchdog: too long without a handshake on either channel means a hang.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
